// ===== hdl/okfq_pkg.sv =====
// ----------------------------------------------------------------------------
// okfq_pkg
// shared types, codes and constants for the ordered key set core
// ----------------------------------------------------------------------------
package okfq_pkg;

   localparam int KEY_BITS     = 31;
   localparam int COUNT_W      = 11;
   localparam int CAPACITY_DEF = 1024;

   // action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_FLOOR  = 2'd2;

   // status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [1:0]          action;
      logic [KEY_BITS-1:0] key;
   } okfq_req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                floor_found;
      logic [KEY_BITS-1:0] floor_key;
      logic [COUNT_W-1:0]  stored_count;
   } okfq_rsp_type;

   // engine status toward the top level
   typedef struct packed {
      logic idle;
      logic done;
   } okfq_stat_type;

endpackage

// ===== hdl/okfq_ram.sv =====
// ----------------------------------------------------------------------------
// okfq_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module okfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/okfq_engine.sv =====
// ----------------------------------------------------------------------------
// okfq_engine
// sequencer for binary search and entry shifting over the sorted key ram
// ----------------------------------------------------------------------------
module okfq_engine #(
   parameter int CAPACITY = okfq_pkg::CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  okfq_pkg::okfq_req_type req,
   input  logic                   done_ready,
   output okfq_pkg::okfq_stat_type stat,
   output okfq_pkg::okfq_rsp_type  rsp
);
   import okfq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SRCH_RD = 7'b0000010,
      S_SRCH_CM = 7'b0000100,
      S_DECIDE  = 7'b0001000,
      S_SHIFT   = 7'b0010000,
      S_PLACE   = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [1:0]          action_ff, action_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       mid_ff, mid_in;
   logic [KEY_BITS-1:0] below_ff, below_in;
   logic [KEY_BITS-1:0] ge_ff, ge_in;
   logic [CW-1:0]       left_ff, left_in;
   logic [AW-1:0]       rp_ff, rp_in;
   logic [AW-1:0]       raddr_ff, raddr_in;
   logic                rv_ff, rv_in;
   logic [1:0]          status_ff, status_in;
   logic                found_ff, found_in;
   logic [KEY_BITS-1:0] floor_ff, floor_in;

   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [KEY_BITS-1:0] wr_data, rd_data;
   logic [CW:0]         mid_sum;
   logic [CW-1:0]       mid_calc;
   logic [CW-1:0]       cnt_m1, rem_cnt, pos_p1;
   logic                equal, is_ins;
   logic [CW+COUNT_W-1:0] cnt_ext;

   okfq_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[CW:1];
   assign cnt_m1   = count_ff - CW'(1);
   assign rem_cnt  = count_ff - lo_ff;
   assign pos_p1   = lo_ff + CW'(1);
   // final lo is the lower bound; ge_ff holds the entry there when it exists
   assign equal    = (lo_ff < count_ff) && (ge_ff == key_ff);
   assign is_ins   = (action_ff == ACT_INSERT);

   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      below_in  = below_ff;
      ge_in     = ge_ff;
      left_in   = left_ff;
      rp_in     = rp_ff;
      raddr_in  = raddr_ff;
      rv_in     = rv_ff;
      status_in = status_ff;
      found_in  = found_ff;
      floor_in  = floor_ff;
      wr_en     = 1'b0;
      wr_addr   = raddr_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = rp_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               action_in = req.action;
               key_in    = req.key;
               lo_in     = '0;
               hi_in     = count_ff;
               status_in = ST_DONE;
               found_in  = 1'b0;
               floor_in  = '0;
               state_in  = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_calc[AW-1:0];
               mid_in   = mid_calc;
               state_in = S_SRCH_CM;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_SRCH_CM: begin
            if (rd_data < key_ff) begin
               lo_in    = mid_ff + CW'(1);
               below_in = rd_data;
            end else begin
               hi_in = mid_ff;
               ge_in = rd_data;
            end
            state_in = S_SRCH_RD;
         end
         S_DECIDE: begin
            state_in = S_DONE;
            rv_in    = 1'b0;
            case (action_ff)
               ACT_INSERT: begin
                  if (equal) begin
                     status_in = ST_PRESENT;
                  end else if (count_ff >= CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     // move entries pos..count-1 up by one, top first
                     left_in  = rem_cnt;
                     rp_in    = cnt_m1[AW-1:0];
                     state_in = S_SHIFT;
                  end
               end
               ACT_REMOVE: begin
                  if (equal) begin
                     // move entries pos+1..count-1 down by one, bottom first
                     count_in = cnt_m1;
                     left_in  = rem_cnt - CW'(1);
                     rp_in    = pos_p1[AW-1:0];
                     state_in = S_SHIFT;
                  end else begin
                     status_in = ST_MISSING;
                  end
               end
               ACT_FLOOR: begin
                  if (equal) begin
                     found_in = 1'b1;
                     floor_in = key_ff;
                  end else if (lo_ff != '0) begin
                     found_in = 1'b1;
                     floor_in = below_ff;
                  end
               end
               default: begin
                  status_in = ST_DONE;
               end
            endcase
         end
         S_SHIFT: begin
            if (rv_ff) begin
               wr_en   = 1'b1;
               wr_addr = is_ins ? (raddr_ff + AW'(1)) : (raddr_ff - AW'(1));
               wr_data = rd_data;
            end
            if (left_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = rp_ff;
               raddr_in = rp_ff;
               rv_in    = 1'b1;
               left_in  = left_ff - CW'(1);
               rp_in    = is_ins ? (rp_ff - AW'(1)) : (rp_ff + AW'(1));
            end else begin
               rv_in = 1'b0;
               if (!rv_ff) begin
                  if (is_ins) begin
                     state_in = S_PLACE;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[AW-1:0];
            wr_data  = key_ff;
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      key_ff    <= key_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      below_ff  <= below_in;
      ge_ff     <= ge_in;
      left_ff   <= left_in;
      rp_ff     <= rp_in;
      raddr_ff  <= raddr_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      floor_ff  <= floor_in;
   end

   assign cnt_ext = {{COUNT_W{1'b0}}, count_ff};

   assign stat.idle         = (state_ff == S_IDLE);
   assign stat.done         = (state_ff == S_DONE);
   assign rsp.status        = status_ff;
   assign rsp.floor_found   = found_ff;
   assign rsp.floor_key     = floor_ff;
   assign rsp.stored_count  = cnt_ext[COUNT_W-1:0];

endmodule

// ===== hdl/ordered_key_set_with_floor_query_core.sv =====
// ----------------------------------------------------------------------------
// ordered_key_set_with_floor_query_core
// bounded ordered key set with insert, remove and floor query
// ----------------------------------------------------------------------------
// usage
//   req channel (valid/ready) carries one transaction: an action code and a
//   key. insert adds a key, remove deletes one, floor returns the largest
//   stored key not above the given key. rsp channel returns exactly one
//   transaction per request: status, floor flag/key and the key count.
//   keys sit in ascending order in one ram. each request runs a binary
//   search through the ram read port (each probe: issue, then compare),
//   then an insert or remove moves the entries above the position one slot,
//   one entry per cycle through the same read/write port pair.
//   with n keys held and p the search position, floor, failed ops and
//   duplicates end after the search and the decide state; an insert then
//   shifts n - p entries and writes the key in the place state, and a
//   remove shifts n - p - 1 entries (none when the top key goes).
//   req_ready returns in the same cycle as the result reaches the output
//   register; one request is in work at a time, set by the ram port.
//   reset empties the set at once (count cleared, no ram sweep) and drops
//   any pending response. a stalled receiver does not block the next
//   request; only when the output register is still full does the engine
//   hold its finished result and wait.
// ----------------------------------------------------------------------------
module ordered_key_set_with_floor_query_core #(
   parameter int CAPACITY = okfq_pkg::CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  okfq_pkg::okfq_req_type req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output okfq_pkg::okfq_rsp_type rsp
);
   import okfq_pkg::*;

   okfq_stat_type eng_stat;
   okfq_rsp_type  eng_rsp;
   okfq_rsp_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          start;
   logic          done_ready;

   // new transaction only when the engine sits idle
   assign req_ready = eng_stat.idle && !reset;
   assign start     = req_valid && req_ready;

   // output register free, or being emptied this cycle
   assign done_ready = !rsp_valid_ff || rsp_ready;

   okfq_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req),
      .done_ready (done_ready),
      .stat       (eng_stat),
      .rsp        (eng_rsp)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (eng_stat.done && done_ready) begin
         rsp_in       = eng_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hdl/okfq_chk.sv =====
// ----------------------------------------------------------------------------
// okfq_chk
// port-level checks for the ordered key set core, bound to the top level
// ----------------------------------------------------------------------------
module okfq_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input okfq_pkg::okfq_rsp_type rsp
);
   import okfq_pkg::*;

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response changed while stalled");

   // the engine leaves idle on acceptance, so the block is busy right after a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting a request");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // floor key is zero whenever no floor was found
   a_floor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.floor_found |-> rsp.floor_key == '0)
      else $error("floor key set without floor found");

   // only a plain completed transaction can report a floor
   a_floor_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.floor_found |-> rsp.status == ST_DONE)
      else $error("floor found with error status");

endmodule

bind ordered_key_set_with_floor_query_core okfq_chk u_okfq_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
